>>> src/integer_partition_generator_core_assert.svh
// ----------------------------------------------------------------------------
// Integer partition generator assertion macros
// Shared assertion forms; the enclosing module supplies clk and rst.
// ----------------------------------------------------------------------------
`ifndef INTEGER_PARTITION_GENERATOR_CORE_ASSERT_SVH
`define INTEGER_PARTITION_GENERATOR_CORE_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define IPG_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define IPG_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define IPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ipg_pkg.sv
// ----------------------------------------------------------------------------
// Integer partition generator package
// Shared widths, constants, controller states and command/status types.
// ----------------------------------------------------------------------------
package ipg_pkg;

  localparam int MAX_PARTITION_SIZE_DEF = 32;
  localparam int RESULT_LIMIT           = 32;

  localparam int VAL_W = 6;
  localparam int POS_W = 5;
  localparam int SUM_W = 7;

  localparam logic [VAL_W-1:0] PART_ONE = VAL_W'(1);
  localparam logic [VAL_W-1:0] PART_TWO = VAL_W'(2);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADV,
    ST_LOOP,
    ST_EMIT
  } ipg_state_t;

  typedef struct packed {
    logic start;
    logic fill;
    logic exh;
    logic adv_first;
    logic adv_loop;
    logic emit;
    logic rd_emit;
  } ipg_cmd_t;

  typedef struct packed {
    logic done;
    logic adv_more;
    logic loop_cont;
    logic emit_last;
    logic out_free;
  } ipg_stat_t;

endpackage

>>> src/ipg_ctrl.sv
// ----------------------------------------------------------------------------
// Integer partition generator controller
// Sequences restart, successor update and part emission for each item.
// ----------------------------------------------------------------------------
module ipg_ctrl
  import ipg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  logic      restart,
  input  ipg_stat_t stat,
  output ipg_cmd_t  cmd
);

  ipg_state_t state;
  ipg_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = stat.out_free;
        if (s_tvalid && stat.out_free) begin
          cmd.start = 1'b1;
          if (restart) begin
            cmd.fill   = 1'b1;
            state_next = ST_EMIT;
          end else if (stat.done) begin
            cmd.exh = 1'b1;
          end else begin
            state_next = ST_ADV;
          end
        end
      end
      ST_ADV: begin
        cmd.adv_first = 1'b1;
        state_next    = stat.adv_more ? ST_LOOP : ST_EMIT;
      end
      ST_LOOP: begin
        cmd.adv_loop = 1'b1;
        state_next   = stat.loop_cont ? ST_LOOP : ST_EMIT;
      end
      ST_EMIT: begin
        cmd.rd_emit = 1'b1;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.emit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/ipg_datapath.sv
// ----------------------------------------------------------------------------
// Integer partition generator datapath
// Parts store, head and ones-start indexes, successor arithmetic and the
// output register.
// ----------------------------------------------------------------------------
module ipg_datapath
  import ipg_pkg::*;
#(
  parameter int MAX_PARTITION_SIZE = MAX_PARTITION_SIZE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [VAL_W-1:0] cfg_wdata,
  input  ipg_cmd_t         cmd,
  output ipg_stat_t        stat,
  input  logic             m_tready,
  output logic             out_valid,
  output logic [VAL_W-1:0] part_value,
  output logic [POS_W-1:0] part_position,
  output logic             last_part,
  output logic             final_partition,
  output logic             exhausted
);

  `include "integer_partition_generator_core_assert.svh"

  localparam int AW   = (MAX_PARTITION_SIZE > 1) ? $clog2(MAX_PARTITION_SIZE) : 1;
  localparam int NLIM = (MAX_PARTITION_SIZE < RESULT_LIMIT) ? MAX_PARTITION_SIZE
                                                            : RESULT_LIMIT;
  localparam logic [VAL_W-1:0] NLIM_V = VAL_W'(NLIM);

  logic [VAL_W-1:0] partition_size;
  logic [VAL_W-1:0] n;
  logic [VAL_W-1:0] h;
  logic [POS_W-1:0] m;
  logic             done;
  logic [VAL_W-1:0] r;
  logic signed [SUM_W-1:0] t;
  logic [POS_W-1:0] i;
  logic [SUM_W-1:0] sum;
  logic [VAL_W-1:0] parts [MAX_PARTITION_SIZE];

  logic [AW-1:0]    rd_addr;
  logic [VAL_W-1:0] rd_val;
  logic             fin;
  logic [VAL_W-1:0] n_new;
  logic [VAL_W-1:0] n_m1;
  logic [SUM_W-1:0] h_inc;
  logic             h_inc_lt_n;
  logic             h_in_range;
  logic             is_two;
  logic             adv_more;
  logic [VAL_W-1:0] r_first;
  logic signed [SUM_W-1:0] t_first;
  logic signed [SUM_W-1:0] r_s;
  logic             loop_cont;
  logic [VAL_W-1:0] m_plus;
  logic [POS_W-1:0] m_two;
  logic [VAL_W-1:0] m_end_raw;
  logic [POS_W-1:0] m_end;
  logic             tail_write;
  logic [SUM_W-1:0] sum_new;
  logic             emit_last;
  logic             out_free;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [VAL_W-1:0] wr_data;

  always_comb begin
    rd_addr    = cmd.rd_emit ? AW'(i) : AW'(h);
    rd_val     = parts[rd_addr];
    fin        = (parts[0] == PART_ONE);
    if (partition_size == '0) begin
      n_new = PART_ONE;
    end else if (partition_size > NLIM_V) begin
      n_new = NLIM_V;
    end else begin
      n_new = partition_size;
    end
    n_m1       = n - PART_ONE;
    h_inc      = {1'b0, h} + SUM_W'(1);
    h_inc_lt_n = (h_inc < {1'b0, n});
    h_in_range = (h < n);
    is_two     = (rd_val == PART_TWO);
    adv_more   = h_in_range && (rd_val > PART_TWO);
    r_first    = rd_val - PART_ONE;
    t_first    = $signed({2'b00, m}) - $signed({1'b0, h}) + SUM_W'(1);
    r_s        = $signed({1'b0, r});
    loop_cont  = (t >= r_s) && h_inc_lt_n;
    m_plus     = {1'b0, m} + VAL_W'(1);
    m_two      = (m_plus > n_m1) ? n_m1[POS_W-1:0] : m_plus[POS_W-1:0];
    m_end_raw  = (t == '0) ? h : h_inc[VAL_W-1:0];
    m_end      = (m_end_raw > n_m1) ? n_m1[POS_W-1:0] : m_end_raw[POS_W-1:0];
    tail_write = (t != '0) && (t > SUM_W'(1)) && h_inc_lt_n;
    sum_new    = sum + {1'b0, rd_val};
    emit_last  = (sum_new >= {1'b0, n}) || (({1'b0, i} + VAL_W'(1)) >= n);
    out_free   = !out_valid || m_tready;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AW'(h);
    wr_data = PART_ONE;
    if (cmd.adv_first && h_in_range && is_two) begin
      wr_en = 1'b1;
    end else if (cmd.adv_first && adv_more) begin
      wr_en   = 1'b1;
      wr_data = r_first;
    end else if (cmd.adv_loop && loop_cont) begin
      wr_en   = 1'b1;
      wr_addr = AW'(h_inc);
      wr_data = r;
    end else if (cmd.adv_loop && tail_write) begin
      wr_en   = 1'b1;
      wr_addr = AW'(h_inc);
      wr_data = t[VAL_W-1:0];
    end
  end

  assign stat.done      = done;
  assign stat.adv_more  = adv_more;
  assign stat.loop_cont = loop_cont;
  assign stat.emit_last = emit_last;
  assign stat.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      partition_size <= PART_ONE;
    end else if (cfg_we) begin
      partition_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      for (int k = 1; k < MAX_PARTITION_SIZE; k++) begin
        parts[k] <= PART_ONE;
      end
      parts[0] <= n_new;
    end else if (wr_en) begin
      parts[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n    <= PART_ONE;
      h    <= '0;
      m    <= '0;
      done <= 1'b1;
    end else begin
      if (cmd.fill) begin
        n <= n_new;
        h <= '0;
        m <= '0;
      end
      if (cmd.adv_first && h_in_range && is_two) begin
        h <= (h == '0) ? '0 : h - PART_ONE;
        m <= m_two;
      end
      if (cmd.adv_loop) begin
        if (loop_cont) begin
          h <= h_inc[VAL_W-1:0];
        end else begin
          m <= m_end;
          if (tail_write) begin
            h <= h_inc[VAL_W-1:0];
          end
        end
      end
      if (cmd.emit) begin
        done <= fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.adv_first) begin
      r <= r_first;
      t <= t_first;
    end else if (cmd.adv_loop && loop_cont) begin
      t <= t - r_s;
    end
    if (cmd.start) begin
      i   <= '0;
      sum <= '0;
    end else if (cmd.emit) begin
      i   <= i + POS_W'(1);
      sum <= sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.exh) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      part_value      <= rd_val;
      part_position   <= i;
      last_part       <= emit_last;
      final_partition <= fin;
      exhausted       <= 1'b0;
    end else if (cmd.exh) begin
      part_value      <= '0;
      part_position   <= '0;
      last_part       <= 1'b0;
      final_partition <= 1'b0;
      exhausted       <= 1'b1;
    end
  end

  `IPG_ASSERT_ALWAYS(a_size_range, (n != '0) && (n <= NLIM_V), "active size out of range")
  `IPG_ASSERT_ALWAYS(a_ones_below_n, {1'b0, m} < n, "ones start index beyond size")
  `IPG_ASSERT_IMPLY(a_load_free, cmd.emit || cmd.exh, out_free, "output loaded while full")
  `IPG_ASSERT_NEXT(a_exh_item, cmd.exh, out_valid && exhausted && !last_part, "bad exhausted item")

endmodule

>>> src/integer_partition_generator_core.sv
// ----------------------------------------------------------------------------
// Integer partition generator core
// Steps through the partitions of n in reverse lexicographic order (ZS1).
// ----------------------------------------------------------------------------
// Usage:
// cfg_we/cfg_wdata set n; it is taken when a restart item arrives.
// Each input item on s_tvalid/s_tready carries restart in s_tdata[0].
// A restart item loads the partition [n] and sends its single part.
// Any other item moves to the next partition and sends its parts, largest
// first, one output item per cycle while m_tready is high, up to n of them,
// with m_tlast on the last one; after the all-ones partition it gets
// the exhausted answer instead. m_tuser flags the all-ones partition and
// the exhausted answer. A successor step first updates the head part;
// when that part is above two it then refills one part per loop step and
// closes the update with a last loop step. An exhausted answer appears in
// the cycle after its item. The next input item is taken once the last
// part is registered and the output is free. Reset marks the generator
// exhausted with n = 1 until a restart arrives.
// When m_tready is low the output register holds and the core waits.
// ----------------------------------------------------------------------------
module integer_partition_generator_core
  import ipg_pkg::*;
#(
  parameter int MAX_PARTITION_SIZE = MAX_PARTITION_SIZE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [VAL_W-1:0] cfg_wdata,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,  // [0] restart
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [15:0]      m_tdata,  // [5:0] part_value, [10:6] part_position
  output logic             m_tlast,
  output logic [1:0]       m_tuser   // [0] final_partition, [1] exhausted
);

  ipg_cmd_t         cmd;
  ipg_stat_t        stat;
  logic [VAL_W-1:0] part_value;
  logic [POS_W-1:0] part_position;
  logic             final_partition;
  logic             exhausted;

  ipg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .restart  (s_tdata[0]),
    .stat     (stat),
    .cmd      (cmd)
  );

  ipg_datapath #(
    .MAX_PARTITION_SIZE (MAX_PARTITION_SIZE)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .cmd             (cmd),
    .stat            (stat),
    .m_tready        (m_tready),
    .out_valid       (m_tvalid),
    .part_value      (part_value),
    .part_position   (part_position),
    .last_part       (m_tlast),
    .final_partition (final_partition),
    .exhausted       (exhausted)
  );

  assign m_tdata = {5'b0, part_position, part_value};
  assign m_tuser = {exhausted, final_partition};

endmodule
